>>> hdl/ogic_pkg.sv
// Package for the online grid island counter.
// Holds the sequencer state type and field widths; no dependencies.
package ogic_pkg;

    localparam int CountW = 11;
    localparam int CoordW = 5;
    localparam int CfgW   = 6;

    localparam logic CfgRows = 1'b0;
    localparam logic CfgCols = 1'b1;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CLEAR,
        ST_LAND_RD,
        ST_LAND_CHK,
        ST_NB_SEL,
        ST_NB_LAND,
        ST_FA_RD,
        ST_FA_CHK,
        ST_CA_RD,
        ST_CA_CHK,
        ST_FB_RD,
        ST_FB_CHK,
        ST_CB_RD,
        ST_CB_CHK,
        ST_MERGE,
        ST_DONE
    } state_t;

endpackage

>>> hdl/online_grid_island_counter.sv
// Online grid island counter: union-find over a cell grid held in memories.
// Depends on ogic_pkg.
//
// Usage:
//   s_axis: one item per cell that turns to land. tdata = {cell_col, cell_row},
//   cell_row in the lowest bits. m_axis: one result item per input item,
//   tdata = island_count, tuser = {position_error, already_land}.
//   cfg_we/cfg_index/cfg_data write grid_rows (index 0) and grid_cols
//   (index 1); only while the block is idle.
// Sequencing:
//   One item at a time. Error cells go straight to the result; repeat cells
//   read their land mark first; a new cell checks its four neighbors. Each
//   in-grid land neighbor adds a walk of its two root chains (find, then
//   compress) through the single-port parent memory.
//   The next item is taken only once the result has been taken.
// Reset:
//   Land marks sit in a 1-bit memory cleared by a pass over MAX_ROWS*MAX_COLS
//   entries (1024 by default) after reset, s_axis_tready low meanwhile. Parent
//   entries need no clearing: only land entries are read. Count resets to 0.
// Stall:
//   The result sits in an output register; s_axis_tready stays low until it
//   is taken, so nothing is lost when the receiver stalls.
module online_grid_island_counter #(
    parameter int MAX_ROWS = 32,
    parameter int MAX_COLS = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // [4:0] cell_row, [9:5] cell_col
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // [10:0] island_count
    output logic [1:0]  m_axis_tuser,   // [0] already_land, [1] position_error
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [ogic_pkg::CfgW-1:0] cfg_data
);
    import ogic_pkg::*;

    localparam int Cells = MAX_ROWS * MAX_COLS;
    localparam int IdxW  = $clog2(Cells);
    localparam int EffW  = 10;   // holds 63 and any grid size plus one

    logic [IdxW-1:0] parent_mem [Cells];
    logic            land_mem [Cells];

    logic [CfgW-1:0] rows_cfg_reg, cols_cfg_reg;
    state_t state_reg, state_next;
    logic [CoordW-1:0] r_reg;
    logic [CoordW-1:0] c_reg;
    logic [IdxW-1:0] self_reg, nb_reg, walk_reg, root_reg, ra_reg, clr_reg;
    logic [1:0] k_reg;
    logic [CountW-1:0] islands_reg;
    logic [CountW-1:0] out_count_reg;
    logic out_land_reg, out_err_reg, out_valid_reg;

    logic [IdxW-1:0] rd_addr;
    logic [IdxW-1:0] rd_data;
    logic wr_en;
    logic [IdxW-1:0] wr_addr, wr_data;

    logic [IdxW-1:0] land_rd_addr;
    logic            land_rd_data;
    logic            land_we;
    logic [IdxW-1:0] land_wr_addr;
    logic            land_wr_data;

    logic [EffW-1:0] rows_eff, cols_eff;
    logic [EffW-1:0] nr;
    logic [EffW-1:0] nc;
    logic nb_ok;
    logic in_ok;
    logic [IdxW-1:0] nb_idx;

    always_comb
    begin
        rows_eff = ({{(EffW-CfgW){1'b0}}, rows_cfg_reg} > EffW'(MAX_ROWS))
                   ? EffW'(MAX_ROWS) : {{(EffW-CfgW){1'b0}}, rows_cfg_reg};
        cols_eff = ({{(EffW-CfgW){1'b0}}, cols_cfg_reg} > EffW'(MAX_COLS))
                   ? EffW'(MAX_COLS) : {{(EffW-CfgW){1'b0}}, cols_cfg_reg};
        in_ok = (EffW'(s_axis_tdata[4:0]) < rows_eff)
             && (EffW'(s_axis_tdata[9:5]) < cols_eff);
        nr = EffW'(r_reg);
        nc = EffW'(c_reg);
        nb_ok = 1'b1;
        case (k_reg)
            2'd0: nr = nr + 1'b1;
            2'd1: begin nb_ok = (r_reg != '0); nr = nr - 1'b1; end
            2'd2: nc = nc + 1'b1;
            default: begin nb_ok = (c_reg != '0); nc = nc - 1'b1; end
        endcase
        nb_ok = nb_ok && (nr < rows_eff) && (nc < cols_eff);
        nb_idx = IdxW'(int'(nr) * MAX_COLS + int'(nc));
    end

    // single read port, registered read
    always_ff @(posedge clk)
    begin
        if (wr_en)
            parent_mem[wr_addr] <= wr_data;
        rd_data <= parent_mem[rd_addr];
    end

    // land marks, also with a registered read
    always_ff @(posedge clk)
    begin
        if (land_we)
            land_mem[land_wr_addr] <= land_wr_data;
        land_rd_data <= land_mem[land_rd_addr];
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR:    if (clr_reg == IdxW'(Cells - 1))
                             state_next = ST_IDLE;
            ST_IDLE:     if (s_axis_tvalid && s_axis_tready)
                             state_next = in_ok ? ST_LAND_RD : ST_DONE;
            ST_LAND_RD:  state_next = ST_LAND_CHK;
            ST_LAND_CHK: state_next = land_rd_data ? ST_DONE : ST_NB_SEL;
            ST_NB_SEL:   state_next = ST_NB_LAND;
            ST_NB_LAND:  state_next = (nb_ok && land_rd_data) ? ST_FA_RD
                                    : (k_reg == 2'd3) ? ST_DONE : ST_NB_SEL;
            ST_FA_RD:    state_next = ST_FA_CHK;
            ST_FA_CHK:   state_next = (rd_data < walk_reg) ? ST_FA_RD : ST_CA_RD;
            ST_CA_RD:    state_next = ST_CA_CHK;
            ST_CA_CHK:   state_next = (rd_data < walk_reg && walk_reg != root_reg)
                                    ? ST_CA_RD : ST_FB_RD;
            ST_FB_RD:    state_next = ST_FB_CHK;
            ST_FB_CHK:   state_next = (rd_data < walk_reg) ? ST_FB_RD : ST_CB_RD;
            ST_CB_RD:    state_next = ST_CB_CHK;
            ST_CB_CHK:   state_next = (rd_data < walk_reg && walk_reg != root_reg)
                                    ? ST_CB_RD : ST_MERGE;
            ST_MERGE:    state_next = (k_reg == 2'd3) ? ST_DONE : ST_NB_SEL;
            ST_DONE:     state_next = ST_IDLE;
            default:     state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        s_axis_tready = (state_reg == ST_IDLE) && !out_valid_reg;
        rd_addr = walk_reg;
        wr_en = 1'b0;
        wr_addr = walk_reg;
        wr_data = root_reg;
        land_rd_addr = nb_idx;
        land_we = 1'b0;
        land_wr_addr = self_reg;
        land_wr_data = 1'b1;
        case (state_reg)
            ST_CLEAR: begin land_we = 1'b1; land_wr_addr = clr_reg;
                            land_wr_data = 1'b0; end
            ST_LAND_RD: land_rd_addr = self_reg;
            ST_LAND_CHK: begin wr_en = !land_rd_data; wr_addr = self_reg;
                               wr_data = self_reg; land_we = !land_rd_data; end
            ST_CA_CHK, ST_CB_CHK: wr_en = (walk_reg != root_reg);
            ST_MERGE: begin
                wr_en = (ra_reg != root_reg);
                wr_addr = (ra_reg < root_reg) ? root_reg : ra_reg;
                wr_data = (ra_reg < root_reg) ? ra_reg : root_reg;
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
            clr_reg <= '0;
            islands_reg <= '0;
            out_valid_reg <= 1'b0;
            out_count_reg <= '0;
            out_land_reg <= 1'b0;
            out_err_reg <= 1'b0;
            rows_cfg_reg <= CfgW'(32);
            cols_cfg_reg <= CfgW'(32);
            k_reg <= '0;
            r_reg <= '0;
            c_reg <= '0;
            self_reg <= '0;
            nb_reg <= '0;
            walk_reg <= '0;
            root_reg <= '0;
            ra_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
            begin
                if (cfg_index == CfgRows) rows_cfg_reg <= cfg_data;
                else                      cols_cfg_reg <= cfg_data;
            end
            if (m_axis_tvalid && m_axis_tready)
                out_valid_reg <= 1'b0;
            case (state_reg)
                ST_CLEAR: clr_reg <= clr_reg + 1'b1;
                ST_IDLE: if (s_axis_tvalid && s_axis_tready)
                begin
                    r_reg <= s_axis_tdata[4:0];
                    c_reg <= s_axis_tdata[9:5];
                    self_reg <= IdxW'(int'(s_axis_tdata[4:0]) * MAX_COLS
                                      + int'(s_axis_tdata[9:5]));
                    out_err_reg <= !in_ok;
                    out_land_reg <= 1'b0;
                    k_reg <= '0;
                end
                ST_LAND_CHK:
                    if (land_rd_data) out_land_reg <= 1'b1;
                    else              islands_reg <= islands_reg + 1'b1;
                ST_NB_LAND:
                    if (nb_ok && land_rd_data)
                    begin
                        nb_reg <= nb_idx;
                        walk_reg <= nb_idx;
                    end
                    else
                        k_reg <= k_reg + 1'b1;
                ST_FA_CHK, ST_FB_CHK:
                    if (rd_data < walk_reg) walk_reg <= rd_data;
                    else
                    begin
                        root_reg <= walk_reg;
                        walk_reg <= (state_reg == ST_FA_CHK) ? nb_reg : self_reg;
                    end
                ST_CA_CHK, ST_CB_CHK:
                    if (rd_data < walk_reg && walk_reg != root_reg)
                        walk_reg <= rd_data;
                    else if (state_reg == ST_CA_CHK)
                    begin
                        ra_reg <= root_reg;
                        walk_reg <= self_reg;
                    end
                ST_MERGE:
                begin
                    if (ra_reg != root_reg) islands_reg <= islands_reg - 1'b1;
                    k_reg <= k_reg + 1'b1;
                end
                ST_DONE:
                begin
                    out_count_reg <= islands_reg;
                    out_valid_reg <= 1'b1;
                end
                default: ;
            endcase
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata = {{(16-CountW){1'b0}}, out_count_reg};
    assign m_axis_tuser = {out_err_reg, out_land_reg};

`ifndef SYNTH
    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_IDLE) |-> !s_axis_tready)
        else $error("input taken while busy");
    a_flags_excl: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> !(m_axis_tuser[0] && m_axis_tuser[1]))
        else $error("both flags set");
    a_done_valid: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DONE) |=> m_axis_tvalid)
        else $error("result not posted");
    a_hold_result: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tready) |=>
        (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)))
        else $error("result changed while stalled");
`endif

endmodule
